>>> rtl/ycpm_pkg.sv
// Shared types, constants and saturating fixed-point helpers of the yaw cascade PID mixer.
`timescale 1ns / 1ps
package ycpm_pkg;

	// Internal fixed-point word and the formats around it.
	localparam int DATA_W    = 48;
	localparam int EXT_W     = DATA_W + 1;
	localparam int FRAC_BITS = 16;
	localparam int GAIN_W    = 24;
	localparam int GAIN_FRAC = 16;
	localparam int PROD_W    = DATA_W + GAIN_W;
	localparam int MUL_STEPS = GAIN_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

	// Port field widths.
	localparam int HEAD_W    = 16;
	localparam int IN_FRAC   = 6;
	localparam int IN_SHIFT  = FRAC_BITS - IN_FRAC;
	localparam int MODE_W    = 3;
	localparam int SPEED_W   = 10;
	localparam int CNT_W     = 12;
	localparam int EFF_W     = 13;

	// Configuration register widths.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int LIMIT_W    = 10;
	localparam int THR_W      = 16;
	localparam int THR_FRAC   = 8;
	localparam int OFS_W      = 8;
	localparam int SLOPE_W    = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_P_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_I_GAIN_DT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_D_GAIN_DT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FF_THRESHOLD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FF_OFFSET    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FF_SLOPE     = 3'd7;

	// Register reset values.
	localparam logic [GAIN_W-1:0]  RST_OUTER_GAIN   = 24'd65536;
	localparam logic [GAIN_W-1:0]  RST_INNER_P_GAIN = 24'd65536;
	localparam logic [GAIN_W-1:0]  RST_I_GAIN_DT    = 24'd0;
	localparam logic [GAIN_W-1:0]  RST_D_GAIN_DT    = 24'd0;
	localparam logic [LIMIT_W-1:0] RST_INT_LIMIT    = 10'd30;
	localparam logic [THR_W-1:0]   RST_FF_THRESHOLD = 16'd256;
	localparam logic [OFS_W-1:0]   RST_FF_OFFSET    = 8'd45;
	localparam logic [SLOPE_W-1:0] RST_FF_SLOPE     = 16'd55706;

	// Motion modes; the remaining codes hold the previous thruster counts.
	localparam logic [MODE_W-1:0] MODE_STOP     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_BACKWARD = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FORWARD  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RIGHT    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LEFT     = 3'd4;

	// ESC command limits in whole counts.
	localparam logic [CNT_W-1:0] ESC_CENTER  = 12'd1500;
	localparam logic [CNT_W-1:0] ESC_LOWEST  = 12'd1100;
	localparam logic [CNT_W-1:0] ESC_HIGHEST = 12'd1900;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic signed [DATA_W-1:0] ESC_CENTER_FIX =
		{{(DATA_W-CNT_W-FRAC_BITS){1'b0}}, ESC_CENTER, {FRAC_BITS{1'b0}}};
	localparam logic signed [DATA_W-1:0] ESC_LO_FIX =
		{{(DATA_W-CNT_W-FRAC_BITS){1'b0}}, ESC_LOWEST, {FRAC_BITS{1'b0}}};
	localparam logic signed [DATA_W-1:0] ESC_HI_FIX =
		{{(DATA_W-CNT_W-FRAC_BITS){1'b0}}, ESC_HIGHEST, {FRAC_BITS{1'b0}}};

	typedef struct packed {
		logic [GAIN_W-1:0]  outer_gain;
		logic [GAIN_W-1:0]  inner_p_gain;
		logic [GAIN_W-1:0]  i_gain_dt;
		logic [GAIN_W-1:0]  d_gain_per_dt;
		logic [LIMIT_W-1:0] integrator_limit;
		logic [THR_W-1:0]   ff_threshold;
		logic [OFS_W-1:0]   ff_offset;
		logic [SLOPE_W-1:0] ff_slope;
	} cfg_t;

	// Saturate a value one bit wider than the internal word.
	function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [EXT_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[EXT_W-1] != v[DATA_W-1]) begin
			r = v[EXT_W-1] ? SAT_MIN : SAT_MAX;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		logic [EXT_W-1:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		return sat_wide(s);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		logic [EXT_W-1:0] s;
		s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		return sat_wide(s);
	endfunction

	// Clamp a fixed-point count to the ESC range, truncating to whole counts.
	function automatic logic [CNT_W-1:0] esc_clamp(input logic signed [DATA_W-1:0] v);
		logic [CNT_W-1:0] c;
		if (v < ESC_LO_FIX) begin
			c = ESC_LOWEST;
		end else if (v > ESC_HI_FIX) begin
			c = ESC_HIGHEST;
		end else begin
			c = v[FRAC_BITS +: CNT_W];
		end
		return c;
	endfunction

endpackage

>>> rtl/ycpm_cfg_regs.sv
// Configuration register file of the yaw cascade PID mixer.
`timescale 1ns / 1ps
module ycpm_cfg_regs import ycpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outer_gain       <= RST_OUTER_GAIN;
			cfg_q.inner_p_gain     <= RST_INNER_P_GAIN;
			cfg_q.i_gain_dt        <= RST_I_GAIN_DT;
			cfg_q.d_gain_per_dt    <= RST_D_GAIN_DT;
			cfg_q.integrator_limit <= RST_INT_LIMIT;
			cfg_q.ff_threshold     <= RST_FF_THRESHOLD;
			cfg_q.ff_offset        <= RST_FF_OFFSET;
			cfg_q.ff_slope         <= RST_FF_SLOPE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OUTER_GAIN:   cfg_q.outer_gain       <= cfg_data[GAIN_W-1:0];
				REG_INNER_P_GAIN: cfg_q.inner_p_gain     <= cfg_data[GAIN_W-1:0];
				REG_I_GAIN_DT:    cfg_q.i_gain_dt        <= cfg_data[GAIN_W-1:0];
				REG_D_GAIN_DT:    cfg_q.d_gain_per_dt    <= cfg_data[GAIN_W-1:0];
				REG_INT_LIMIT:    cfg_q.integrator_limit <= cfg_data[LIMIT_W-1:0];
				REG_FF_THRESHOLD: cfg_q.ff_threshold     <= cfg_data[THR_W-1:0];
				REG_FF_OFFSET:    cfg_q.ff_offset        <= cfg_data[OFS_W-1:0];
				REG_FF_SLOPE:     cfg_q.ff_slope         <= cfg_data[SLOPE_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/ycpm_serial_mul.sv
// Bit-serial signed-by-unsigned gain multiplier with truncation toward zero and saturation.
`timescale 1ns / 1ps
module ycpm_serial_mul import ycpm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [EXT_W-1:0]  operand,
	input  logic [GAIN_W-1:0]        gain,
	output logic signed [DATA_W-1:0] product,
	output logic                     done
);

	localparam int SCALED_W = PROD_W - GAIN_FRAC;

	logic                     busy_q;
	logic                     fin_q;
	logic                     done_q;
	logic                     neg_q;
	logic [MUL_CNT_W-1:0]     cnt_q;
	logic [DATA_W-1:0]        mag_q;
	logic [GAIN_W-1:0]        gain_q;
	logic [PROD_W-1:0]        prod_q;
	logic signed [DATA_W-1:0] product_q;

	logic [EXT_W-1:0]    op_abs;
	logic [EXT_W-1:0]    step_sum;
	logic [SCALED_W-1:0] scaled;
	logic                over;

	always_comb begin
		op_abs   = operand[EXT_W-1] ? EXT_W'(-operand) : operand;
		// One gain bit per cycle: add the magnitude into the top and shift right.
		step_sum = {1'b0, prod_q[PROD_W-1:GAIN_W]} + (gain_q[0] ? {1'b0, mag_q} : '0);
		scaled   = prod_q[PROD_W-1:GAIN_FRAC];
		over     = |scaled[SCALED_W-1:DATA_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			fin_q     <= 1'b0;
			done_q    <= 1'b0;
			neg_q     <= 1'b0;
			cnt_q     <= '0;
			mag_q     <= '0;
			gain_q    <= '0;
			prod_q    <= '0;
			product_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mag_q  <= op_abs[DATA_W-1:0];
				neg_q  <= operand[EXT_W-1];
				gain_q <= gain;
				prod_q <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				prod_q <= {step_sum, prod_q[GAIN_W-1:1]};
				gain_q <= gain_q >> 1;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				if (over) begin
					product_q <= neg_q ? SAT_MIN : SAT_MAX;
				end else begin
					product_q <= neg_q ? -scaled[DATA_W-1:0] : scaled[DATA_W-1:0];
				end
			end
		end
	end

	assign product = product_q;
	assign done    = done_q;

endmodule

>>> rtl/ycpm_mixer.sv
// Two-stage thruster mixer with ESC clamping, held counts and effort count output.
`timescale 1ns / 1ps
module ycpm_mixer import ycpm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic                    eff_neg,
	input  logic [DATA_W-1:0]       eff_mag,
	input  logic [MODE_W-1:0]       mode,
	input  logic [SPEED_W-1:0]      speed,
	output logic [CNT_W-1:0]        held_a,
	output logic [CNT_W-1:0]        held_b,
	output logic [CNT_W-1:0]        held_c,
	output logic signed [EFF_W-1:0] eff_counts,
	output logic                    done
);

	localparam int Q_W = DATA_W - FRAC_BITS;
	localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(2 ** (EFF_W - 1) - 1);
	localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(2 ** (EFF_W - 1));
	localparam logic signed [EFF_W-1:0] EFF_MAX = {1'b0, {(EFF_W-1){1'b1}}};
	localparam logic signed [EFF_W-1:0] EFF_MIN = {1'b1, {(EFF_W-1){1'b0}}};

	logic                     valid_s1;
	logic signed [DATA_W-1:0] base_s1;
	logic [MODE_W-1:0]        mode_s1;
	logic [SPEED_W-1:0]       speed_s1;
	logic signed [EFF_W-1:0]  eff_counts_s1;
	logic [CNT_W-1:0]         held_a_q;
	logic [CNT_W-1:0]         held_b_q;
	logic [CNT_W-1:0]         held_c_q;
	logic                     done_q;

	logic signed [DATA_W-1:0] base;
	logic [Q_W-1:0]           q;
	logic signed [EFF_W-1:0]  counts;
	logic signed [DATA_W-1:0] sp_fix;
	logic signed [DATA_W-1:0] base_up;
	logic signed [DATA_W-1:0] base_dn;
	logic signed [DATA_W-1:0] ctr_up;
	logic signed [DATA_W-1:0] ctr_dn;

	// Stage one: thruster base from the signed effort, and the effort in whole counts.
	always_comb begin
		base = eff_neg ? sat_add(ESC_CENTER_FIX, eff_mag) : sat_sub(ESC_CENTER_FIX, eff_mag);
		q    = eff_mag[DATA_W-1:FRAC_BITS];
		if (!eff_neg) begin
			counts = (q > POS_LIMIT) ? EFF_MAX : q[EFF_W-1:0];
		end else begin
			counts = (q > NEG_LIMIT) ? EFF_MIN : -q[EFF_W-1:0];
		end
	end

	// Stage two: translation offsets.
	always_comb begin
		sp_fix  = {{(DATA_W-SPEED_W-FRAC_BITS){1'b0}}, speed_s1, {FRAC_BITS{1'b0}}};
		base_up = sat_add(base_s1, sp_fix);
		base_dn = sat_sub(base_s1, sp_fix);
		ctr_up  = ESC_CENTER_FIX + sp_fix;
		ctr_dn  = ESC_CENTER_FIX - sp_fix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			base_s1       <= '0;
			mode_s1       <= '0;
			speed_s1      <= '0;
			eff_counts_s1 <= '0;
			held_a_q      <= ESC_CENTER;
			held_b_q      <= ESC_CENTER;
			held_c_q      <= ESC_CENTER;
			done_q        <= 1'b0;
		end else begin
			valid_s1 <= go;
			done_q   <= valid_s1;
			if (go) begin
				base_s1       <= base;
				mode_s1       <= mode;
				speed_s1      <= speed;
				eff_counts_s1 <= counts;
			end
			if (valid_s1) begin
				unique case (mode_s1)
					MODE_STOP: begin
						held_a_q <= esc_clamp(ESC_CENTER_FIX);
						held_b_q <= esc_clamp(base_s1);
						held_c_q <= esc_clamp(base_s1);
					end
					MODE_BACKWARD: begin
						held_a_q <= esc_clamp(ctr_dn);
						held_b_q <= esc_clamp(base_s1);
						held_c_q <= esc_clamp(base_dn);
					end
					MODE_FORWARD: begin
						held_a_q <= esc_clamp(ctr_up);
						held_b_q <= esc_clamp(base_s1);
						held_c_q <= esc_clamp(base_up);
					end
					MODE_RIGHT: begin
						held_a_q <= esc_clamp(ctr_dn);
						held_b_q <= esc_clamp(base_dn);
						held_c_q <= esc_clamp(base_s1);
					end
					MODE_LEFT: begin
						held_a_q <= esc_clamp(ctr_up);
						held_b_q <= esc_clamp(base_up);
						held_c_q <= esc_clamp(base_s1);
					end
					default: begin
						held_a_q <= held_a_q;
						held_b_q <= held_b_q;
						held_c_q <= held_c_q;
					end
				endcase
			end
		end
	end

	assign held_a     = held_a_q;
	assign held_b     = held_b_q;
	assign held_c     = held_c_q;
	assign eff_counts = eff_counts_s1;
	assign done       = done_q;

endmodule

>>> rtl/yaw_cascade_pid_mixer.sv
// Top level of the yaw cascade PID controller with deadband compensation and thruster mixer.
// All five gain products run one after another on one bit-serial multiplier, each with a
// load and a final scaling step; the last is skipped when the effort falls inside the deadband.
// A new input is taken only once the sequencer has handed the previous result on.
// A new input is taken while a finished result still waits in the output register.
// Reset clears the integrator and previous rate error, sets held counts to ESC neutral.
`timescale 1ns / 1ps
module yaw_cascade_pid_mixer import ycpm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration write port.
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	// Input channel.
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [HEAD_W-1:0] target_heading,
	input  logic signed [HEAD_W-1:0] measured_heading,
	input  logic signed [HEAD_W-1:0] heading_rate,
	input  logic [MODE_W-1:0]        motion_mode,
	input  logic [SPEED_W-1:0]       travel_speed,
	// Output channel.
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CNT_W-1:0]         thruster_a,
	output logic [CNT_W-1:0]         thruster_b,
	output logic [CNT_W-1:0]         thruster_c,
	output logic signed [EFF_W-1:0]  yaw_effort
);

	// The sequencer walks through the controller one product at a time. Each product has a
	// GO state that loads the multiplier and a WAIT state that folds the product into the
	// loop state once the multiplier reports done.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OUTER_GO,
		ST_OUTER_WAIT,
		ST_P_GO,
		ST_P_WAIT,
		ST_D_GO,
		ST_D_WAIT,
		ST_I_GO,
		ST_I_WAIT,
		ST_EFF,
		ST_ABS,
		ST_FF_GO,
		ST_FF_WAIT,
		ST_MIX,
		ST_MIX_WAIT,
		ST_OUT
	} state_t;

	cfg_t cfg;

	state_t                   state_q;
	logic signed [HEAD_W-1:0] tgt_q;
	logic signed [HEAD_W-1:0] meas_q;
	logic signed [HEAD_W-1:0] rate_q;
	logic [MODE_W-1:0]        mode_q;
	logic [SPEED_W-1:0]       speed_q;

	// Loop state that survives from tick to tick.
	logic signed [DATA_W-1:0] integ_q;
	logic signed [DATA_W-1:0] prev_q;

	// Intermediate values of the current tick.
	logic signed [DATA_W-1:0] err_q;
	logic signed [DATA_W-1:0] p_q;
	logic signed [DATA_W-1:0] d_in_q;
	logic signed [DATA_W-1:0] pd_q;
	logic signed [DATA_W-1:0] effort_q;
	logic                     eff_neg_q;
	logic [DATA_W-1:0]        eff_mag_q;

	// Output register; it parts the output channel from the sequencer.
	logic                     out_valid_q;
	logic [CNT_W-1:0]         thruster_a_q;
	logic [CNT_W-1:0]         thruster_b_q;
	logic [CNT_W-1:0]         thruster_c_q;
	logic signed [EFF_W-1:0]  yaw_effort_q;

	logic                     mul_start;
	logic signed [EXT_W-1:0]  mul_operand;
	logic [GAIN_W-1:0]        mul_gain;
	logic signed [DATA_W-1:0] mul_product;
	logic                     mul_done;

	logic                     mix_go;
	logic [CNT_W-1:0]         mix_a;
	logic [CNT_W-1:0]         mix_b;
	logic [CNT_W-1:0]         mix_c;
	logic signed [EFF_W-1:0]  mix_eff;
	logic                     mix_done;

	logic signed [HEAD_W:0]   ang_diff;
	logic signed [EXT_W-1:0]  ang_op;
	logic signed [DATA_W-1:0] rate_fix;
	logic signed [DATA_W-1:0] lim_fix;
	logic signed [DATA_W-1:0] lim_neg;
	logic signed [DATA_W-1:0] integ_sum;
	logic signed [DATA_W-1:0] integ_next;
	logic [DATA_W-1:0]        thr_fix;
	logic signed [DATA_W-1:0] ofs_fix;
	logic signed [DATA_W-1:0] ff_m;
	logic                     deadband;

	ycpm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ycpm_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.operand (mul_operand),
		.gain    (mul_gain),
		.product (mul_product),
		.done    (mul_done)
	);

	ycpm_mixer u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (mix_go),
		.eff_neg    (eff_neg_q),
		.eff_mag    (eff_mag_q),
		.mode       (mode_q),
		.speed      (speed_q),
		.held_a     (mix_a),
		.held_b     (mix_b),
		.held_c     (mix_c),
		.eff_counts (mix_eff),
		.done       (mix_done)
	);

	// Fixed-point views of the inputs and registers. Headings and rate arrive with six
	// fraction bits and are shifted up to the internal format.
	always_comb begin
		ang_diff = {tgt_q[HEAD_W-1], tgt_q} - {meas_q[HEAD_W-1], meas_q};
		ang_op   = {{(EXT_W-HEAD_W-1-IN_SHIFT){ang_diff[HEAD_W]}}, ang_diff, {IN_SHIFT{1'b0}}};
		rate_fix = {{(DATA_W-HEAD_W-IN_SHIFT){rate_q[HEAD_W-1]}}, rate_q, {IN_SHIFT{1'b0}}};
		lim_fix  = {{(DATA_W-LIMIT_W-FRAC_BITS){1'b0}}, cfg.integrator_limit,
			{FRAC_BITS{1'b0}}};
		lim_neg  = -lim_fix;
		thr_fix  = {{(DATA_W-THR_W-(FRAC_BITS-THR_FRAC)){1'b0}}, cfg.ff_threshold,
			{(FRAC_BITS-THR_FRAC){1'b0}}};
		ofs_fix  = {{(DATA_W-OFS_W-FRAC_BITS){1'b0}}, cfg.ff_offset, {FRAC_BITS{1'b0}}};
		deadband = eff_mag_q < thr_fix;
		ff_m     = sat_add(ofs_fix, mul_product);
	end

	// The integrator is clamped symmetrically to the configured limit after each update.
	always_comb begin
		integ_sum = sat_add(integ_q, mul_product);
		if (integ_sum < lim_neg) begin
			integ_next = lim_neg;
		end else if (integ_sum > lim_fix) begin
			integ_next = lim_fix;
		end else begin
			integ_next = integ_sum;
		end
	end

	// Operand selection for the shared multiplier. The deadband compensation product is
	// skipped entirely when the effort magnitude stays below the threshold.
	always_comb begin
		mul_start   = 1'b0;
		mul_operand = ang_op;
		mul_gain    = cfg.outer_gain;
		unique case (state_q)
			ST_OUTER_GO: begin
				mul_start   = 1'b1;
				mul_operand = ang_op;
				mul_gain    = cfg.outer_gain;
			end
			ST_P_GO: begin
				mul_start   = 1'b1;
				mul_operand = {err_q[DATA_W-1], err_q};
				mul_gain    = cfg.inner_p_gain;
			end
			ST_D_GO: begin
				mul_start   = 1'b1;
				mul_operand = {d_in_q[DATA_W-1], d_in_q};
				mul_gain    = cfg.d_gain_per_dt;
			end
			ST_I_GO: begin
				mul_start   = 1'b1;
				mul_operand = {err_q[DATA_W-1], err_q};
				mul_gain    = cfg.i_gain_dt;
			end
			ST_FF_GO: begin
				mul_start   = !deadband;
				mul_operand = {1'b0, eff_mag_q};
				mul_gain    = {{(GAIN_W-SLOPE_W){1'b0}}, cfg.ff_slope};
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign mix_go   = (state_q == ST_MIX);
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tgt_q        <= '0;
			meas_q       <= '0;
			rate_q       <= '0;
			mode_q       <= '0;
			speed_q      <= '0;
			integ_q      <= '0;
			prev_q       <= '0;
			err_q        <= '0;
			p_q          <= '0;
			d_in_q       <= '0;
			pd_q         <= '0;
			effort_q     <= '0;
			eff_neg_q    <= 1'b0;
			eff_mag_q    <= '0;
			out_valid_q  <= 1'b0;
			thruster_a_q <= ESC_CENTER;
			thruster_b_q <= ESC_CENTER;
			thruster_c_q <= ESC_CENTER;
			yaw_effort_q <= '0;
		end else begin
			// A waiting result leaves on its transfer; in ST_OUT the load below takes its
			// place in the same cycle.
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						tgt_q   <= target_heading;
						meas_q  <= measured_heading;
						rate_q  <= heading_rate;
						mode_q  <= motion_mode;
						speed_q <= travel_speed;
						state_q <= ST_OUTER_GO;
					end
				end
				ST_OUTER_GO: state_q <= ST_OUTER_WAIT;
				ST_OUTER_WAIT: begin
					// Rate error: the rate target from the angle loop minus the measured rate.
					if (mul_done) begin
						err_q   <= sat_sub(mul_product, rate_fix);
						state_q <= ST_P_GO;
					end
				end
				ST_P_GO: state_q <= ST_P_WAIT;
				ST_P_WAIT: begin
					// The derivative acts on the change of rate error since the last tick.
					if (mul_done) begin
						p_q     <= mul_product;
						d_in_q  <= sat_sub(err_q, prev_q);
						prev_q  <= err_q;
						state_q <= ST_D_GO;
					end
				end
				ST_D_GO: state_q <= ST_D_WAIT;
				ST_D_WAIT: begin
					if (mul_done) begin
						pd_q    <= sat_add(p_q, mul_product);
						state_q <= ST_I_GO;
					end
				end
				ST_I_GO: state_q <= ST_I_WAIT;
				ST_I_WAIT: begin
					if (mul_done) begin
						integ_q <= integ_next;
						state_q <= ST_EFF;
					end
				end
				ST_EFF: begin
					effort_q <= sat_add(pd_q, integ_q);
					state_q  <= ST_ABS;
				end
				ST_ABS: begin
					// Sign and magnitude travel apart from here on; the magnitude of the
					// most negative value still fits the unsigned word.
					eff_neg_q <= effort_q[DATA_W-1];
					eff_mag_q <= effort_q[DATA_W-1] ? -effort_q : effort_q;
					state_q   <= ST_FF_GO;
				end
				ST_FF_GO: begin
					if (deadband) begin
						eff_mag_q <= '0;
						state_q   <= ST_MIX;
					end else begin
						state_q <= ST_FF_WAIT;
					end
				end
				ST_FF_WAIT: begin
					// Compensated magnitude: fixed ESC offset plus slope times magnitude.
					if (mul_done) begin
						eff_mag_q <= ff_m;
						state_q   <= ST_MIX;
					end
				end
				ST_MIX: state_q <= ST_MIX_WAIT;
				ST_MIX_WAIT: begin
					if (mix_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Load the result once the output register is empty or being drained.
					if (!out_valid_q || !out_stall) begin
						thruster_a_q <= mix_a;
						thruster_b_q <= mix_b;
						thruster_c_q <= mix_c;
						yaw_effort_q <= mix_eff;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign thruster_a = thruster_a_q;
	assign thruster_b = thruster_b_q;
	assign thruster_c = thruster_c_q;
	assign yaw_effort = yaw_effort_q;

endmodule

>>> test/yaw_cascade_pid_mixer_tb.sv
// Self-checking testbench for the yaw cascade PID mixer: directed and random control ticks.
`timescale 1ns / 1ps
module yaw_cascade_pid_mixer_tb;
	import ycpm_pkg::*;

	localparam int RESET_CYCLES = 10;
	// Long receiver hold-off, in cycles, that lets the block fill up and stall its input.
	localparam int LONG_HOLD    = 700;
	// Watchdog limit; the long hold-off and a stall streak stay far below this.
	localparam int QUIET_LIMIT  = 4000;
	// Cycles to wait after the last result for anything stray to show up.
	localparam int END_SETTLE   = 200;

	// Mode codes above MODE_LEFT repeat the previous thruster counts.
	localparam logic [MODE_W-1:0] MODE_HOLD_FIRST  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_HOLD_SECOND = 3'd6;
	localparam logic [MODE_W-1:0] MODE_HOLD_LAST   = 3'd7;

	typedef struct packed {
		logic [CNT_W-1:0]        a;
		logic [CNT_W-1:0]        b;
		logic [CNT_W-1:0]        c;
		logic signed [EFF_W-1:0] effort;
	} command_t;

	// Tracks the controller state the way the block should, queues the thruster commands
	// each accepted tick must produce, and checks the commands that come out.
	class yaw_command_ledger;
		cfg_t             regs;
		longint           rate_integral;
		longint           last_rate_err;
		logic [CNT_W-1:0] held_a;
		logic [CNT_W-1:0] held_b;
		logic [CNT_W-1:0] held_c;
		command_t         pending_commands[$];
		int               mismatches = 0;
		int               results_seen = 0;
		int               shown_limit = 50;

		function new();
			regs.outer_gain       = RST_OUTER_GAIN;
			regs.inner_p_gain     = RST_INNER_P_GAIN;
			regs.i_gain_dt        = RST_I_GAIN_DT;
			regs.d_gain_per_dt    = RST_D_GAIN_DT;
			regs.integrator_limit = RST_INT_LIMIT;
			regs.ff_threshold     = RST_FF_THRESHOLD;
			regs.ff_offset        = RST_FF_OFFSET;
			regs.ff_slope         = RST_FF_SLOPE;
			rate_integral = 0;
			last_rate_err = 0;
			held_a = ESC_CENTER;
			held_b = ESC_CENTER;
			held_c = ESC_CENTER;
		endfunction

		function longint sat48(longint v);
			if (v > SAT_MAX) return SAT_MAX;
			if (v < SAT_MIN) return SAT_MIN;
			return v;
		endfunction

		// Product of a fixed-point value and an unsigned Q8.16 gain, formed on the magnitude,
		// truncated toward zero and saturated.
		function longint gain_mul(longint v, logic [GAIN_W-1:0] g);
			bit neg;
			longint unsigned m, hi, lo, r, top, gg;
			neg = v < 0;
			m   = neg ? -v : v;
			gg  = g;
			hi  = m >> 24;
			lo  = m & 64'hFF_FFFF;
			r   = ((hi * gg) << (24 - GAIN_FRAC)) + ((lo * gg) >> GAIN_FRAC);
			top = SAT_MAX;
			top = top + 1;
			if (r > top) r = top;
			return neg ? sat48(-longint'(r)) : sat48(longint'(r));
		endfunction

		function longint whole_counts(longint v);
			if (v < 0) return -((-v) >> FRAC_BITS);
			return v >> FRAC_BITS;
		endfunction

		function logic [CNT_W-1:0] esc_limit(longint v);
			longint whole;
			if (v < (longint'(ESC_LOWEST) << FRAC_BITS)) return ESC_LOWEST;
			if (v > (longint'(ESC_HIGHEST) << FRAC_BITS)) return ESC_HIGHEST;
			whole = whole_counts(v);
			return whole[CNT_W-1:0];
		endfunction

		// Runs one control tick and queues the command it must produce.
		function void add_tick(logic signed [HEAD_W-1:0] target,
				logic signed [HEAD_W-1:0] measured, logic signed [HEAD_W-1:0] rate_in,
				logic [MODE_W-1:0] mode, logic [SPEED_W-1:0] speed);
			longint rate, speed_fix, center, ang_err, rate_goal, err;
			longint p_term, d_term, lim, effort, mag, m, base, cnt;
			command_t cmd;
			rate      = longint'(rate_in) * (longint'(1) << IN_SHIFT);
			speed_fix = longint'(speed) << FRAC_BITS;
			center    = longint'(ESC_CENTER) << FRAC_BITS;
			ang_err   = (longint'(target) - longint'(measured)) * (longint'(1) << IN_SHIFT);

			// Outer loop turns the heading error into a rate goal; inner PID works on the rate.
			rate_goal = gain_mul(ang_err, regs.outer_gain);
			err       = sat48(rate_goal - rate);
			p_term    = gain_mul(err, regs.inner_p_gain);
			d_term    = gain_mul(sat48(err - last_rate_err), regs.d_gain_per_dt);
			lim       = longint'(regs.integrator_limit) << FRAC_BITS;
			rate_integral = sat48(rate_integral + gain_mul(err, regs.i_gain_dt));
			if (rate_integral < -lim) begin
				rate_integral = -lim;
			end else if (rate_integral > lim) begin
				rate_integral = lim;
			end
			effort = sat48(sat48(p_term + d_term) + rate_integral);

			// Deadband compensation: small efforts vanish, others get offset plus slope.
			mag = (effort < 0) ? -effort : effort;
			if (mag < (longint'(regs.ff_threshold) << (FRAC_BITS - THR_FRAC))) begin
				effort = 0;
			end else begin
				m = sat48((longint'(regs.ff_offset) << FRAC_BITS) + gain_mul(mag, regs.ff_slope));
				effort = (effort < 0) ? -m : m;
			end

			base = sat48(center - effort);
			case (mode)
				MODE_STOP: begin
					held_a = esc_limit(center);
					held_b = esc_limit(base);
					held_c = esc_limit(base);
				end
				MODE_BACKWARD: begin
					held_a = esc_limit(center - speed_fix);
					held_b = esc_limit(base);
					held_c = esc_limit(sat48(base - speed_fix));
				end
				MODE_FORWARD: begin
					held_a = esc_limit(center + speed_fix);
					held_b = esc_limit(base);
					held_c = esc_limit(sat48(base + speed_fix));
				end
				MODE_RIGHT: begin
					held_a = esc_limit(center - speed_fix);
					held_b = esc_limit(sat48(base - speed_fix));
					held_c = esc_limit(base);
				end
				MODE_LEFT: begin
					held_a = esc_limit(center + speed_fix);
					held_b = esc_limit(sat48(base + speed_fix));
					held_c = esc_limit(base);
				end
				default: begin
				end
			endcase
			last_rate_err = err;

			cnt = whole_counts(effort);
			if (cnt > (longint'(1) << (EFF_W - 1)) - 1) cnt = (longint'(1) << (EFF_W - 1)) - 1;
			if (cnt < -(longint'(1) << (EFF_W - 1))) cnt = -(longint'(1) << (EFF_W - 1));
			cmd.a      = held_a;
			cmd.b      = held_b;
			cmd.c      = held_c;
			cmd.effort = cnt[EFF_W-1:0];
			pending_commands.push_back(cmd);
		endfunction

		task report(string what);
			if (mismatches < shown_limit) $display("MISMATCH %s", what);
			mismatches++;
		endtask

		task check_command(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b, logic [CNT_W-1:0] c,
				logic signed [EFF_W-1:0] effort);
			command_t want;
			results_seen++;
			if (pending_commands.size() == 0) begin
				report($sformatf("result %0d arrived with no tick waiting", results_seen));
				return;
			end
			want = pending_commands.pop_front();
			if (a !== want.a)
				report($sformatf("result %0d thruster_a %0d, want %0d", results_seen, a, want.a));
			if (b !== want.b)
				report($sformatf("result %0d thruster_b %0d, want %0d", results_seen, b, want.b));
			if (c !== want.c)
				report($sformatf("result %0d thruster_c %0d, want %0d", results_seen, c, want.c));
			if (effort !== want.effort)
				report($sformatf("result %0d yaw_effort %0d, want %0d", results_seen, effort,
					want.effort));
		endtask

		task flush();
			if (pending_commands.size() != 0)
				report($sformatf("%0d ticks never produced a result", pending_commands.size()));
		endtask
	endclass

	logic                    clk              = 1'b0;
	logic                    arst_n           = 1'b0;
	logic                    cfg_we           = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index        = '0;
	logic [CFG_DATA_W-1:0]   cfg_data         = '0;
	logic                    in_valid         = 1'b0;
	logic                    in_stall;
	logic signed [HEAD_W-1:0] target_heading   = '0;
	logic signed [HEAD_W-1:0] measured_heading = '0;
	logic signed [HEAD_W-1:0] heading_rate     = '0;
	logic [MODE_W-1:0]       motion_mode      = '0;
	logic [SPEED_W-1:0]      travel_speed     = '0;
	logic                    out_valid;
	logic                    out_stall        = 1'b0;
	logic [CNT_W-1:0]        thruster_a;
	logic [CNT_W-1:0]        thruster_b;
	logic [CNT_W-1:0]        thruster_c;
	logic signed [EFF_W-1:0] yaw_effort;

	yaw_command_ledger ledger;

	// Idle rates in percent; written by the main sequence only right after a rising edge.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// The main sequence raises hold_go; the receiver turns it into a counted hold-off.
	bit hold_go        = 1'b0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	yaw_cascade_pid_mixer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.target_heading   (target_heading),
		.measured_heading (measured_heading),
		.heading_rate     (heading_rate),
		.motion_mode      (motion_mode),
		.travel_speed     (travel_speed),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.thruster_a       (thruster_a),
		.thruster_b       (thruster_b),
		.thruster_c       (thruster_c),
		.yaw_effort       (yaw_effort)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random stalls at the current rate, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = LONG_HOLD;
			hold_go   = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Every result transfer is checked against the oldest queued command.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.check_command(thruster_a, thruster_b, thruster_c, yaw_effort);
	end

	// Watchdog: too long without a transfer on either channel means the block hung.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("yaw_cascade_pid_mixer_tb failed");
			$finish;
		end
	end

	// Offers one tick, with random idle cycles ahead of it, and holds it until the transfer.
	// Starts at a falling edge and returns right after the accepting rising edge, so the
	// next call sets valid exactly once in its own falling edge.
	task automatic send_tick(input logic signed [HEAD_W-1:0] target,
			input logic signed [HEAD_W-1:0] measured, input logic signed [HEAD_W-1:0] rate_in,
			input logic [MODE_W-1:0] mode, input logic [SPEED_W-1:0] speed);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid         <= 1'b1;
		target_heading   <= target;
		measured_heading <= measured;
		heading_rate     <= rate_in;
		motion_mode      <= mode;
		travel_speed     <= speed;
		do @(posedge clk); while (in_stall);
		ledger.add_tick(target, measured, rate_in, mode, speed);
	endtask

	// Most ticks sit near a steady heading so efforts land around the deadband and the ESC
	// limits; a quarter cover the full field ranges.
	task automatic send_random_tick();
		logic signed [HEAD_W-1:0] target, measured, rate_in;
		logic [MODE_W-1:0]        mode;
		logic [SPEED_W-1:0]       speed;
		target = HEAD_W'($urandom);
		if ($urandom_range(99) < 25) begin
			measured = HEAD_W'($urandom);
			rate_in  = HEAD_W'($urandom);
		end else begin
			measured = target + HEAD_W'(int'($urandom_range(0, 400)) - 200);
			rate_in  = HEAD_W'(int'($urandom_range(0, 600)) - 300);
		end
		if ($urandom_range(99) < 80) begin
			mode = MODE_W'($urandom_range(MODE_STOP, MODE_LEFT));
		end else begin
			mode = MODE_W'($urandom_range(MODE_HOLD_FIRST, MODE_HOLD_LAST));
		end
		speed = $urandom_range(1) ? SPEED_W'($urandom) : SPEED_W'($urandom_range(0, 100));
		send_tick(target, measured, rate_in, mode, speed);
	endtask

	// Drops valid and waits until every queued command has come out.
	task automatic wait_for_commands();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.pending_commands.size() != 0);
	endtask

	// Writes all eight registers back to back while the block is idle.
	task automatic load_settings(input cfg_t s);
		logic [CFG_DATA_W-1:0] field [1 << CFG_IDX_W];
		field[REG_OUTER_GAIN]   = CFG_DATA_W'(s.outer_gain);
		field[REG_INNER_P_GAIN] = CFG_DATA_W'(s.inner_p_gain);
		field[REG_I_GAIN_DT]    = CFG_DATA_W'(s.i_gain_dt);
		field[REG_D_GAIN_DT]    = CFG_DATA_W'(s.d_gain_per_dt);
		field[REG_INT_LIMIT]    = CFG_DATA_W'(s.integrator_limit);
		field[REG_FF_THRESHOLD] = CFG_DATA_W'(s.ff_threshold);
		field[REG_FF_OFFSET]    = CFG_DATA_W'(s.ff_offset);
		field[REG_FF_SLOPE]     = CFG_DATA_W'(s.ff_slope);
		for (int k = 0; k < (1 << CFG_IDX_W); k++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(k);
			cfg_data  <= field[k];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		ledger.regs = s;
		@(posedge clk);
	endtask

	function automatic cfg_t tuned_settings();
		cfg_t s;
		s.outer_gain       = 24'd131072;
		s.inner_p_gain     = 24'd98304;
		s.i_gain_dt        = 24'd3277;
		s.d_gain_per_dt    = 24'd19661;
		s.integrator_limit = 10'd200;
		s.ff_threshold     = 16'd128;
		s.ff_offset        = 8'd30;
		s.ff_slope         = 16'd52429;
		return s;
	endfunction

	// Mostly moderate gains so the thrusters are not pinned at a limit, now and then anything.
	function automatic cfg_t random_settings();
		cfg_t s;
		s.outer_gain    = ($urandom_range(3) == 0) ? GAIN_W'($urandom)
			: GAIN_W'($urandom_range(0, 262143));
		s.inner_p_gain  = ($urandom_range(3) == 0) ? GAIN_W'($urandom)
			: GAIN_W'($urandom_range(0, 262143));
		s.i_gain_dt     = ($urandom_range(3) == 0) ? GAIN_W'($urandom)
			: GAIN_W'($urandom_range(0, 16383));
		s.d_gain_per_dt = ($urandom_range(3) == 0) ? GAIN_W'($urandom)
			: GAIN_W'($urandom_range(0, 131071));
		s.integrator_limit = LIMIT_W'($urandom);
		s.ff_threshold     = $urandom_range(1) ? THR_W'($urandom_range(0, 1023)) : THR_W'($urandom);
		s.ff_offset        = OFS_W'($urandom);
		s.ff_slope         = SLOPE_W'($urandom);
		return s;
	endfunction

	// One stretch of random ticks under one register setting and one idling pattern.
	task automatic run_phase(input cfg_t s, input int count, input int send_pct,
			input int recv_pct, input bit long_hold);
		wait_for_commands();
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		load_settings(s);
		for (int i = 0; i < count; i++) begin
			send_random_tick();
			if (long_hold && i == 10) hold_go = 1'b1;
		end
	endtask

	// Directed ticks under the reset settings: a hold before any move, the deadband edge,
	// the field extremes, every motion mode and both ends of the ESC range.
	task automatic directed_ticks();
		send_tick(0, 0, 0, MODE_HOLD_LAST, 1023);
		send_tick(0, 0, 0, MODE_STOP, 0);
		send_tick(63, 0, 0, MODE_STOP, 0);
		send_tick(64, 0, 0, MODE_STOP, 0);
		send_tick(0, 64, 0, MODE_STOP, 0);
		send_tick(32767, -32768, -32768, MODE_STOP, 0);
		send_tick(-32768, 32767, 32767, MODE_STOP, 0);
		send_tick(0, 0, 32767, MODE_BACKWARD, 1023);
		send_tick(640, 0, 0, MODE_BACKWARD, 0);
		send_tick(-640, 0, 0, MODE_FORWARD, 1023);
		send_tick(1280, 0, 0, MODE_FORWARD, 200);
		send_tick(0, 1280, 0, MODE_RIGHT, 1023);
		send_tick(320, 0, -320, MODE_RIGHT, 0);
		send_tick(0, 320, 320, MODE_LEFT, 1023);
		send_tick(-320, 0, 100, MODE_LEFT, 400);
		send_tick(5000, 0, 0, MODE_HOLD_FIRST, 1023);
		send_tick(-5000, 0, 0, MODE_HOLD_SECOND, 0);
		send_tick(0, 0, 0, MODE_HOLD_LAST, 512);
		send_tick(32767, 32767, 0, MODE_FORWARD, 1023);
		send_tick(-32768, -32768, 0, MODE_BACKWARD, 1023);
		send_tick(0, 0, -32768, MODE_LEFT, 1023);
		send_tick(100, -100, -1, MODE_STOP, 1);
		send_tick(0, 0, 1, MODE_RIGHT, 0);
	endtask

	initial begin
		ledger = new();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_ticks();
		// Sender never idles here, and the receiver holds off long enough to back up the block.
		run_phase(tuned_settings(), 350, 0, 0, 1'b1);
		// Every register at its largest value, then every register at zero.
		run_phase('1, 200, 58, 0, 1'b0);
		run_phase('0, 200, 0, 58, 1'b0);
		run_phase(random_settings(), 450, 32, 32, 1'b0);
		run_phase(tuned_settings(), 450, 0, 58, 1'b0);
		run_phase(random_settings(), 200, 58, 0, 1'b0);

		wait_for_commands();
		repeat (END_SETTLE) @(posedge clk);
		ledger.flush();
		if (ledger.mismatches == 0) begin
			$display("yaw_cascade_pid_mixer_tb passed");
		end else begin
			$display("yaw_cascade_pid_mixer_tb failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/ycpm_pkg.sv
rtl/ycpm_cfg_regs.sv
rtl/ycpm_serial_mul.sv
rtl/ycpm_mixer.sv
rtl/yaw_cascade_pid_mixer.sv
test/yaw_cascade_pid_mixer_tb.sv
